// ===== rtl/cbm_pkg.sv =====
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int OFFSET_BITS_DEFAULT = 22;
    localparam int FULL_OFFSET_BITS = 22;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_MAPPER_KIND       = 2'd0;
    localparam logic [1:0] REG_PRG_BANK_COUNT    = 2'd1;
    localparam logic [1:0] REG_CHR_UNIT_COUNT    = 2'd2;
    localparam logic [1:0] REG_INITIAL_MIRRORING = 2'd3;

    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_PRG_READ  = 2'd1;
    localparam logic [1:0] OP_CHR_FETCH = 2'd2;
    localparam logic [1:0] OP_NT_FETCH  = 2'd3;

    localparam logic [1:0] MIRROR_ONE_LOW   = 2'd0;
    localparam logic [1:0] MIRROR_ONE_HIGH  = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL  = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

    localparam logic [3:0] KIND_SERIAL   = 4'd1;
    localparam logic [3:0] KIND_PRG_LOW  = 4'd2;
    localparam logic [3:0] KIND_CHR_8K   = 4'd3;
    localparam logic [3:0] KIND_PRG_32K  = 4'd7;

    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR0    = 2'd1;
    localparam logic [1:0] SEL_CHR1    = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    localparam logic [7:0] SERIAL_RELOAD = 8'd5;
    localparam logic [4:0] SERIAL_RESET_BITS = 5'd12;

    localparam logic [3:0] MAPPER_KIND_RESET       = 4'd0;
    localparam logic [6:0] PRG_BANK_COUNT_RESET    = 7'd2;
    localparam logic [7:0] CHR_UNIT_COUNT_RESET    = 8'd0;
    localparam logic [1:0] INITIAL_MIRRORING_RESET = MIRROR_VERTICAL;

    localparam logic [7:0] PRG_HIGH_RESET = 8'({1'b0, PRG_BANK_COUNT_RESET} - 8'd1);
    localparam logic [7:0] CHR_HIGH_RESET = 8'd1;

    typedef struct packed {
        logic [3:0] mapper_kind;
        logic [6:0] prg_bank_count;
        logic [7:0] chr_unit_count;
        logic [1:0] initial_mirroring;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } item_t;

endpackage

// ===== rtl/cbm_cfg.sv =====
`timescale 1ns / 1ps

module cbm_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [cbm_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [cbm_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output cbm_pkg::cfg_t                      cfg,
    output logic                               cfg_load
);
    import cbm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic load_reg;
    logic load_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;
    assign cfg_load = load_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        load_next = 1'b0;
        if (wr_en)
        begin
            load_next = 1'b1;
            case (paddr[3:2])
                REG_MAPPER_KIND:       cfg_next.mapper_kind = pwdata[3:0];
                REG_PRG_BANK_COUNT:    cfg_next.prg_bank_count = pwdata[6:0];
                REG_CHR_UNIT_COUNT:    cfg_next.chr_unit_count = pwdata[7:0];
                REG_INITIAL_MIRRORING: cfg_next.initial_mirroring = pwdata[1:0];
                default:               load_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAPPER_KIND:       prdata = CFG_DATA_BITS'(cfg_reg.mapper_kind);
            REG_PRG_BANK_COUNT:    prdata = CFG_DATA_BITS'(cfg_reg.prg_bank_count);
            REG_CHR_UNIT_COUNT:    prdata = CFG_DATA_BITS'(cfg_reg.chr_unit_count);
            REG_INITIAL_MIRRORING: prdata = CFG_DATA_BITS'(cfg_reg.initial_mirroring);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_kind       <= MAPPER_KIND_RESET;
            cfg_reg.prg_bank_count    <= PRG_BANK_COUNT_RESET;
            cfg_reg.chr_unit_count    <= CHR_UNIT_COUNT_RESET;
            cfg_reg.initial_mirroring <= INITIAL_MIRRORING_RESET;
            load_reg                  <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            load_reg <= load_next;
        end
    end

endmodule

// ===== rtl/cbm_xlate.sv =====
`timescale 1ns / 1ps

module cbm_xlate
#(
    parameter int OFFSET_BITS = cbm_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cbm_pkg::cfg_t          cfg,
    input  logic                   cfg_load,
    input  logic                   fire,
    input  cbm_pkg::item_t         item,
    output logic [OFFSET_BITS-1:0] offset,
    output logic [1:0]             mirroring
);
    import cbm_pkg::*;

    logic [7:0] prg_bank_low_reg, prg_bank_low_next;
    logic [7:0] prg_bank_high_reg, prg_bank_high_next;
    logic [7:0] chr_bank_low_reg, chr_bank_low_next;
    logic [7:0] chr_bank_high_reg, chr_bank_high_next;
    logic [1:0] mirror_mode_reg, mirror_mode_next;
    logic [7:0] serial_count_reg, serial_count_next;
    logic [4:0] serial_data_reg, serial_data_next;
    logic [4:0] serial_control_reg, serial_control_next;
    logic [4:0] serial_chr0_reg, serial_chr0_next;
    logic [4:0] serial_chr1_reg, serial_chr1_next;
    logic [4:0] serial_prg_reg, serial_prg_next;

    logic [7:0] prg_last;
    logic [7:0] chr_units;
    logic [7:0] bank_sel;
    logic [FULL_OFFSET_BITS-1:0] full_offset;

    assign prg_last = {1'b0, cfg.prg_bank_count} - 8'd1;
    assign chr_units = (cfg.chr_unit_count == 8'd0) ? 8'd1 : cfg.chr_unit_count;

    always_comb
    begin
        prg_bank_low_next   = prg_bank_low_reg;
        prg_bank_high_next  = prg_bank_high_reg;
        chr_bank_low_next   = chr_bank_low_reg;
        chr_bank_high_next  = chr_bank_high_reg;
        mirror_mode_next    = mirror_mode_reg;
        serial_count_next   = serial_count_reg;
        serial_data_next    = serial_data_reg;
        serial_control_next = serial_control_reg;
        serial_chr0_next    = serial_chr0_reg;
        serial_chr1_next    = serial_chr1_reg;
        serial_prg_next     = serial_prg_reg;

        if (cfg_load)
        begin
            prg_bank_low_next  = 8'd0;
            prg_bank_high_next = prg_last;
            chr_bank_low_next  = 8'd0;
            chr_bank_high_next = {chr_units[6:0], 1'b0} - 8'd1;
            mirror_mode_next   = cfg.initial_mirroring;
        end
        else if (fire && item.opcode == OP_CPU_WRITE)
        begin
            case (cfg.mapper_kind)
                KIND_PRG_32K:
                begin
                    mirror_mode_next = (item.data[7:4] != 4'd0) ? MIRROR_ONE_LOW
                                                                 : MIRROR_ONE_HIGH;
                    prg_bank_low_next  = {4'd0, item.data[2:0], 1'b0};
                    prg_bank_high_next = {4'd0, item.data[2:0], 1'b1};
                end
                KIND_CHR_8K:
                begin
                    chr_bank_low_next  = {5'd0, item.data[1:0], 1'b0};
                    chr_bank_high_next = {5'd0, item.data[1:0], 1'b1};
                end
                KIND_PRG_LOW:
                begin
                    prg_bank_low_next = {3'd0, item.data[4:0]};
                end
                KIND_SERIAL:
                begin
                    if (item.data[7])
                    begin
                        serial_count_next   = SERIAL_RELOAD;
                        serial_data_next    = 5'd0;
                        serial_control_next = serial_control_reg | SERIAL_RESET_BITS;
                    end
                    else
                    begin
                        serial_data_next  = {item.data[0], serial_data_reg[4:1]};
                        serial_count_next = serial_count_reg - 8'd1;
                        if (serial_count_next == 8'd0)
                        begin
                            serial_count_next = SERIAL_RELOAD;
                            case (item.address[14:13])
                                SEL_CONTROL:
                                begin
                                    mirror_mode_next    = serial_data_next[1:0];
                                    serial_control_next = serial_data_next;
                                end
                                SEL_CHR0: serial_chr0_next = serial_data_next;
                                SEL_CHR1: serial_chr1_next = serial_data_next;
                                default:  serial_prg_next  = serial_data_next;
                            endcase
                            if (serial_control_next[4])
                            begin
                                chr_bank_low_next  = {3'd0, serial_chr0_next};
                                chr_bank_high_next = {3'd0, serial_chr1_next};
                            end
                            else
                            begin
                                chr_bank_low_next  = {3'd0, serial_chr0_next[4:1], 1'b0};
                                chr_bank_high_next = {3'd0, serial_chr0_next[4:1], 1'b1};
                            end
                            case (serial_control_next[3:2])
                                PRG_MODE_FIX_LOW:
                                begin
                                    prg_bank_low_next  = 8'd0;
                                    prg_bank_high_next = {3'd0, serial_prg_next};
                                end
                                PRG_MODE_FIX_HIGH:
                                begin
                                    prg_bank_low_next  = {3'd0, serial_prg_next};
                                    prg_bank_high_next = prg_last;
                                end
                                default:
                                begin
                                    prg_bank_low_next  = {3'd0, serial_prg_next[4:1], 1'b0};
                                    prg_bank_high_next = {3'd0, serial_prg_next[4:1], 1'b1};
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // translation sees the banks after this beat's update
    always_comb
    begin
        bank_sel = 8'd0;
        case (item.opcode)
            OP_CPU_WRITE, OP_PRG_READ:
            begin
                bank_sel = item.address[14] ? prg_bank_high_next : prg_bank_low_next;
                full_offset = {bank_sel, item.address[13:0]};
            end
            OP_CHR_FETCH:
            begin
                bank_sel = item.address[12] ? chr_bank_high_next : chr_bank_low_next;
                full_offset = FULL_OFFSET_BITS'({bank_sel, item.address[11:0]});
            end
            default:
            begin
                case (mirror_mode_next)
                    MIRROR_ONE_LOW:
                        full_offset = FULL_OFFSET_BITS'({1'b0, item.address[9:0]});
                    MIRROR_ONE_HIGH:
                        full_offset = FULL_OFFSET_BITS'({1'b1, item.address[9:0]});
                    MIRROR_VERTICAL:
                        full_offset = FULL_OFFSET_BITS'(item.address[10:0]);
                    default:
                        full_offset = FULL_OFFSET_BITS'({item.address[11],
                                                         item.address[9:0]});
                endcase
            end
        endcase
    end

    assign offset = OFFSET_BITS'(full_offset);
    assign mirroring = mirror_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_low_reg   <= 8'd0;
            prg_bank_high_reg  <= PRG_HIGH_RESET;
            chr_bank_low_reg   <= 8'd0;
            chr_bank_high_reg  <= CHR_HIGH_RESET;
            mirror_mode_reg    <= INITIAL_MIRRORING_RESET;
            serial_count_reg   <= 8'd0;
            serial_data_reg    <= 5'd0;
            serial_control_reg <= 5'd0;
            serial_chr0_reg    <= 5'd0;
            serial_chr1_reg    <= 5'd0;
            serial_prg_reg     <= 5'd0;
        end
        else
        begin
            prg_bank_low_reg   <= prg_bank_low_next;
            prg_bank_high_reg  <= prg_bank_high_next;
            chr_bank_low_reg   <= chr_bank_low_next;
            chr_bank_high_reg  <= chr_bank_high_next;
            mirror_mode_reg    <= mirror_mode_next;
            serial_count_reg   <= serial_count_next;
            serial_data_reg    <= serial_data_next;
            serial_control_reg <= serial_control_next;
            serial_chr0_reg    <= serial_chr0_next;
            serial_chr1_reg    <= serial_chr1_next;
            serial_prg_reg     <= serial_prg_next;
        end
    end

endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// cartridge bank mapper: translates cpu and ppu accesses through the cartridge bank state
// input stream s_*: one access per beat, s_tuser carries the opcode
//   (cpu write, program read, pattern fetch, nametable fetch)
// output stream m_*: one result per input beat, in order: translated offset and mirroring
// m_tvalid rises when the input register's beat is moved into the output register
// throughput: one beat per cycle unless m_tready stalls; the bank state is updated
//   and read in the same cycle that the result register is loaded
// an input register and an output register decouple the two sides; s_tready stays high
//   while the output register can drain, so a stalled m_tready holds one result in the
//   output register and one access in the input register before s_tready falls
// apb port holds mapper kind, program bank count, pattern unit count and initial
//   mirroring; any write, via a registered strobe, reloads the bank registers and mirroring
// reset (rst_n low, asynchronous) empties both registers, restores the register
//   defaults and loads the banks from them; the serial loader counter starts at zero
module cartridge_bank_mapper
#(
    parameter int OFFSET_BITS = cbm_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [23:0]                               s_tdata,  // address, data
    input  logic [1:0]                                s_tuser,  // opcode
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((OFFSET_BITS + 2 + 7) / 8) * 8-1:0] m_tdata,  // offset, mirroring
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [cbm_pkg::CFG_ADDR_BITS-1:0]         paddr,
    input  logic [cbm_pkg::CFG_DATA_BITS-1:0]         pwdata,
    output logic [cbm_pkg::CFG_DATA_BITS-1:0]         prdata,
    output logic                                      pready
);
    import cbm_pkg::*;

    localparam int OUT_TDATA_BITS = ((OFFSET_BITS + 2 + 7) / 8) * 8;

    cfg_t cfg;
    logic cfg_load;

    logic  in_valid_reg, in_valid_next;
    item_t item_reg;
    logic  out_valid_reg, out_valid_next;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [1:0] out_mirror_reg;
    logic [OFFSET_BITS-1:0] xl_offset;
    logic [1:0] xl_mirror;
    logic advance;
    logic in_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire = s_tvalid && s_tready;
    assign in_valid_next = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_TDATA_BITS'({out_mirror_reg, out_offset_reg});

    cbm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .cfg_load (cfg_load)
    );

    cbm_xlate #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_xlate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_load  (cfg_load),
        .fire      (advance),
        .item      (item_reg),
        .offset    (xl_offset),
        .mirroring (xl_mirror)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.opcode  <= s_tuser;
            item_reg.address <= s_tdata[15:0];
            item_reg.data    <= s_tdata[23:16];
        end
        if (advance)
        begin
            out_offset_reg <= xl_offset;
            out_mirror_reg <= xl_mirror;
        end
    end

endmodule
